[src/mts_pkg.sv]
// mts_pkg: shared types, character codes and entity prefix tables
// for the markup tag stripper; no dependencies
package mts_pkg;

  // results one input byte can cause, terminator included
  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned IDX_W       = 3;

  // character codes
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // entity matcher progress
  typedef enum logic [3:0] {
    EM_IDLE = 4'd0,
    EM_AMP1 = 4'd1,  // "&"
    EM_A    = 4'd2,  // "&a"
    EM_AM   = 4'd3,  // "&am"
    EM_AMP  = 4'd4,  // "&amp"
    EM_L    = 4'd5,  // "&l"
    EM_LT   = 4'd6,  // "&lt"
    EM_G    = 4'd7,  // "&g"
    EM_GT   = 4'd8   // "&gt"
  } em_t;

  // parser state kept between bytes
  typedef struct packed {
    logic tag;
    logic sup;
    em_t  em;
    logic ns;
  } state_t;

  localparam state_t STATE_IDLE = '{tag: 1'b0, sup: 1'b0, em: EM_IDLE, ns: 1'b0};

  // results of one input byte, handed to the output serializer
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [IDX_W-1:0]            count;
    logic                        term;
    logic [31:0]                 length;
  } burst_t;

  // letters matched after the '&' for each matcher state
  function automatic logic [1:0] pfx_len(em_t em);
    logic [1:0] len;
    unique case (em)
      EM_A, EM_L, EM_G:   len = 2'd1;
      EM_AM, EM_LT, EM_GT: len = 2'd2;
      EM_AMP:             len = 2'd3;
      default:            len = 2'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] pfx_chr(em_t em, logic [1:0] k);
    logic [7:0] ch;
    ch = CH_NUL;
    priority case (em)
      EM_A, EM_AM, EM_AMP: begin
        ch = (k == 2'd0) ? CH_A : ((k == 2'd1) ? CH_M : CH_P);
      end
      EM_L, EM_LT: begin
        ch = (k == 2'd0) ? CH_L : CH_T;
      end
      EM_G, EM_GT: begin
        ch = (k == 2'd0) ? CH_G : CH_T;
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

[src/mts_decode.sv]
// mts_decode: single-pass byte decoder, next parser state and result burst
// depends on mts_pkg
module mts_decode #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic [7:0]             text_byte,
  input  logic                   last_byte,
  input  mts_pkg::state_t        state,
  input  logic [COUNT_WIDTH-1:0] count,
  output mts_pkg::state_t        state_next,
  output logic [COUNT_WIDTH-1:0] count_next,
  output mts_pkg::burst_t        burst
);

  typedef struct packed {
    logic       emit;
    logic [7:0] ch;
    logic       tag;
    logic       sup;
    logic       go_ent;
  } plain_t;

  // byte handling with no entity pending
  function automatic plain_t plain_fn(logic [7:0] c, logic tag, logic sup);
    plain_t p;
    p.emit   = 1'b0;
    p.ch     = mts_pkg::CH_SPACE;
    p.tag    = tag;
    p.sup    = sup;
    p.go_ent = 1'b0;
    if (c == mts_pkg::CH_LT) begin
      p.tag = 1'b1;
    end else if (c == mts_pkg::CH_GT) begin
      p.tag  = 1'b0;
      p.emit = !sup;
      p.sup  = 1'b1;
    end else if (tag) begin
      p.tag = 1'b1;
    end else if (c == mts_pkg::CH_AMP) begin
      p.go_ent = 1'b1;
    end else if (c == mts_pkg::CH_SPACE ||
                 (c >= mts_pkg::CH_TAB && c <= mts_pkg::CH_CR)) begin
      p.emit = !sup;
      p.sup  = 1'b1;
    end else begin
      p.emit = 1'b1;
      p.ch   = c;
      p.sup  = 1'b0;
    end
    return p;
  endfunction

  logic [COUNT_WIDTH:0]                 sum;
  logic [COUNT_WIDTH-1:0]               count_sat;
  logic [31:0]                          length_sat;
  logic [2:0]                           nchar;
  logic [mts_pkg::MAX_RESULTS-1:0][7:0] burst_bytes;
  logic [mts_pkg::IDX_W-1:0]            burst_count;

  // decode one byte into up to six results
  always_comb begin
    logic                                     tag;
    logic                                     sup;
    logic                                     ns;
    mts_pkg::em_t                             em;
    logic [mts_pkg::IDX_W-1:0]                n;
    logic [mts_pkg::MAX_RESULTS-1:0][7:0]     bytes;
    logic                                     do_plain;
    plain_t                                   pr;
    tag      = state.tag;
    sup      = state.sup;
    ns       = state.ns;
    em       = state.em;
    n        = '0;
    bytes    = '0;
    do_plain = 1'b0;
    pr       = '0;

    if (ns) begin
      // numeric entity: drop everything up to ';'
      if (text_byte == mts_pkg::CH_SEMI) begin
        bytes[n] = mts_pkg::CH_SPACE;
        n        = n + 1'b1;
        sup      = 1'b0;
        ns       = 1'b0;
      end
    end else if (em != mts_pkg::EM_IDLE) begin
      // entity matching
      if (em == mts_pkg::EM_AMP1 && text_byte == mts_pkg::CH_A) begin
        em = mts_pkg::EM_A;
      end else if (em == mts_pkg::EM_AMP1 && text_byte == mts_pkg::CH_L) begin
        em = mts_pkg::EM_L;
      end else if (em == mts_pkg::EM_AMP1 && text_byte == mts_pkg::CH_G) begin
        em = mts_pkg::EM_G;
      end else if (em == mts_pkg::EM_AMP1 && text_byte == mts_pkg::CH_HASH) begin
        em = mts_pkg::EM_IDLE;
        ns = 1'b1;
      end else if (em == mts_pkg::EM_A && text_byte == mts_pkg::CH_M) begin
        em = mts_pkg::EM_AM;
      end else if (em == mts_pkg::EM_AM && text_byte == mts_pkg::CH_P) begin
        em = mts_pkg::EM_AMP;
      end else if (em == mts_pkg::EM_L && text_byte == mts_pkg::CH_T) begin
        em = mts_pkg::EM_LT;
      end else if (em == mts_pkg::EM_G && text_byte == mts_pkg::CH_T) begin
        em = mts_pkg::EM_GT;
      end else if (text_byte == mts_pkg::CH_SEMI && em == mts_pkg::EM_AMP) begin
        bytes[n] = mts_pkg::CH_AMP;
        n        = n + 1'b1;
        sup      = 1'b0;
        em       = mts_pkg::EM_IDLE;
      end else if (text_byte == mts_pkg::CH_SEMI && em == mts_pkg::EM_LT) begin
        bytes[n] = mts_pkg::CH_LT;
        n        = n + 1'b1;
        sup      = 1'b0;
        em       = mts_pkg::EM_IDLE;
      end else if (text_byte == mts_pkg::CH_SEMI && em == mts_pkg::EM_GT) begin
        bytes[n] = mts_pkg::CH_GT;
        n        = n + 1'b1;
        sup      = 1'b0;
        em       = mts_pkg::EM_IDLE;
      end else begin
        // mismatch: replay '&' and matched letters literally
        bytes[n] = mts_pkg::CH_AMP;
        n        = n + 1'b1;
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < mts_pkg::pfx_len(em)) begin
            bytes[n] = mts_pkg::pfx_chr(em, 2'(k));
            n        = n + 1'b1;
          end
        end
        sup      = 1'b0;
        em       = mts_pkg::EM_IDLE;
        do_plain = 1'b1;
      end
    end else begin
      do_plain = 1'b1;
    end

    // plain byte path
    if (do_plain) begin
      pr  = plain_fn(text_byte, tag, sup);
      tag = pr.tag;
      sup = pr.sup;
      if (pr.go_ent) begin
        em = mts_pkg::EM_AMP1;
      end
      if (pr.emit) begin
        bytes[n] = pr.ch;
        n        = n + 1'b1;
      end
    end

    // end of text: flush partial entity and open numeric entity
    if (last_byte) begin
      if (em != mts_pkg::EM_IDLE) begin
        bytes[n] = mts_pkg::CH_AMP;
        n        = n + 1'b1;
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < mts_pkg::pfx_len(em)) begin
            bytes[n] = mts_pkg::pfx_chr(em, 2'(k));
            n        = n + 1'b1;
          end
        end
        em = mts_pkg::EM_IDLE;
      end
      if (ns) begin
        bytes[n] = mts_pkg::CH_SPACE;
        n        = n + 1'b1;
        ns       = 1'b0;
      end
    end

    nchar = n;
    // terminator entry carries a zero byte
    if (last_byte) begin
      bytes[n] = mts_pkg::CH_NUL;
      n        = n + 1'b1;
    end

    burst_bytes = bytes;
    burst_count = n;

    if (last_byte) begin
      state_next = mts_pkg::STATE_IDLE;
    end else begin
      state_next.tag = tag;
      state_next.sup = sup;
      state_next.em  = em;
      state_next.ns  = ns;
    end
  end

  // saturating emitted-byte count
  assign sum       = {1'b0, count} + (COUNT_WIDTH + 1)'(nchar);
  assign count_sat = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

  generate
    if (COUNT_WIDTH > 32) begin : g_clamp
      assign length_sat = (|count_sat[COUNT_WIDTH-1:32]) ? '1 : count_sat[31:0];
    end else begin : g_extend
      assign length_sat = 32'(count_sat);
    end
  endgenerate

  assign count_next = last_byte ? '0 : count_sat;

  // burst handed to the result register
  assign burst = '{bytes: burst_bytes, count: burst_count, term: last_byte,
                   length: length_sat};

endmodule

[src/mts_burst_buf.sv]
// mts_burst_buf: result register holding one byte's burst and sending it
// out one result per cycle while the receiver is ready; depends on mts_pkg
module mts_burst_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  mts_pkg::burst_t       burst_in,
  output logic                  free,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [7:0]            out_byte,
  output logic                  run_last,
  output logic                  end_of_text,
  output logic [31:0]           text_length
);

  mts_pkg::burst_t           held;
  logic [mts_pkg::IDX_W-1:0] idx;
  logic                      busy;
  logic                      at_end;

  assign at_end = (idx == held.count - 1'b1);
  assign free   = !busy || (result_ready && at_end);

  // burst register and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && result_ready) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= burst_in;
    end
  end

  // current result
  assign result_valid = busy;
  assign out_byte     = held.bytes[idx];
  assign run_last     = at_end;
  assign end_of_text  = at_end && held.term;
  assign text_length  = (at_end && held.term) ? held.length : '0;

  // pointer stays inside the held burst
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx < held.count))
    else $error("burst pointer past end of burst");

  // a stalled result keeps its place
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && !result_ready) |=> (busy && $stable(idx)))
    else $error("burst pointer moved during stall");

  // new burst only when the old one is done or finishing
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("burst overwritten while results pending");

endmodule

[src/markup_tag_stripper_unit.sv]
// markup_tag_stripper_unit: XHTML byte stream to plain text, top level
// depends on mts_pkg, mts_decode, mts_burst_buf
//
// Input channel: text_valid/text_ready carry text_byte and last_byte, one
// markup byte per transfer. Output channel: result_valid/result_ready carry
// out_byte, run_last, end_of_text and text_length, one plain-text byte per
// transfer; run_last marks the final result of an input byte and the
// terminator after the last byte carries end_of_text and the length.
// Each byte is decoded in the cycle it transfers and its results (zero to
// six) land in the burst register; the first result is offered the next
// cycle. The burst register sends one result per cycle while the receiver
// is ready; a byte with several results holds off the next byte until its
// final result is taken. text_ready stays high while the last pending
// result is taken, so one byte per cycle holds if each has at most one result.
// Reset clears the parser state, byte count, burst busy flag and pointer.
// When the receiver stalls, the current result holds and text_ready drops
// until the final result of the held burst transfers.
module markup_tag_stripper_unit #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  text_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        end_of_text,
  output logic [31:0] text_length
);

  mts_pkg::state_t        state;
  mts_pkg::state_t        state_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  mts_pkg::burst_t        burst;
  logic                   free;
  logic                   accept;

  assign text_ready = free;
  assign accept     = text_valid && free;

  // byte decoder
  mts_decode #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_decode (
    .text_byte (text_byte),
    .last_byte (last_byte),
    .state     (state),
    .count     (count),
    .state_next(state_next),
    .count_next(count_next),
    .burst     (burst)
  );

  // parser state and count advance on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mts_pkg::STATE_IDLE;
      count <= '0;
    end else if (accept) begin
      state <= state_next;
      count <= count_next;
    end
  end

  // result register and serializer
  mts_burst_buf u_burst_buf (
    .clk         (clk),
    .rst         (rst),
    .load        (accept && (burst.count != '0)),
    .burst_in    (burst),
    .free        (free),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .end_of_text (end_of_text),
    .text_length (text_length)
  );

  // the final byte always brings the parser back to idle
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (state == mts_pkg::STATE_IDLE && count == '0))
    else $error("state not cleared after end of text");

  // a new byte while results wait only when the last one is being taken
  a_accept_pending: assert property (@(posedge clk) disable iff (rst)
    (accept && result_valid) |-> (result_ready && run_last))
    else $error("input taken while results pending");

  // numeric skip and entity match never both active
  a_skip_excl: assert property (@(posedge clk) disable iff (rst)
    state.ns |-> (state.em == mts_pkg::EM_IDLE))
    else $error("numeric skip with entity pending");

endmodule

[sim/markup_tag_stripper_unit_tb.sv]
// markup_tag_stripper_unit_tb: self-checking bench for the markup tag stripper
// depends on mts_pkg and markup_tag_stripper_unit; a byte-level predictor builds
// the expected plain text, which is checked against every result transfer
`timescale 1ns / 1ps

module markup_tag_stripper_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 450;

  // one markup byte as sent on the input channel
  typedef struct packed {
    logic [7:0] b;
    logic       lst;
  } markup_item_t;

  // one plain-text result as seen on the output channel
  typedef struct packed {
    logic [7:0]  b;
    logic        rl;
    logic        eot;
    logic [31:0] len;
  } text_result_t;

  // kinds of random markup fragments
  typedef enum int {
    TK_WORD,
    TK_SPACE,
    TK_TAG,
    TK_ENTITY,
    TK_PARTIAL,
    TK_NUMERIC,
    TK_STRAY_GT,
    TK_NOISE
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_ready;
  logic [7:0]  text_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        end_of_text;
  logic [31:0] text_length;

  markup_item_t markup_q[$];
  text_result_t plain_q[$];
  text_result_t burst[$];
  text_result_t want;

  // predictor state
  logic         tag_open;
  logic         sup;
  mts_pkg::em_t em;
  logic         num_skip;
  logic [31:0]  emitted;

  int unsigned total_items;
  int unsigned accepted;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned ready_cycles;
  int unsigned ready_mode;

  markup_tag_stripper_unit uut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_ready  (text_ready),
    .text_byte   (text_byte),
    .last_byte   (last_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .end_of_text (end_of_text),
    .text_length (text_length)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  task automatic emit_char(input logic [7:0] c);
    burst.push_back(text_result_t'{b: c, rl: 1'b0, eot: 1'b0, len: 32'd0});
    if (emitted != 32'hFFFF_FFFF) begin
      emitted = emitted + 32'd1;
    end
  endtask

  function automatic logic is_white(input logic [7:0] c);
    return (c == mts_pkg::CH_SPACE) || (c >= mts_pkg::CH_TAB && c <= mts_pkg::CH_CR);
  endfunction

  task automatic plain_step(input logic [7:0] c);
    if (c == mts_pkg::CH_LT) begin
      tag_open = 1'b1;
    end else if (c == mts_pkg::CH_GT) begin
      tag_open = 1'b0;
      if (!sup) begin
        emit_char(mts_pkg::CH_SPACE);
        sup = 1'b1;
      end
    end else if (!tag_open) begin
      if (c == mts_pkg::CH_AMP) begin
        em = mts_pkg::EM_AMP1;
      end else if (is_white(c)) begin
        if (!sup) begin
          emit_char(mts_pkg::CH_SPACE);
          sup = 1'b1;
        end
      end else begin
        emit_char(c);
        sup = 1'b0;
      end
    end
  endtask

  // partial entity goes out literally
  task automatic replay_prefix();
    emit_char(mts_pkg::CH_AMP);
    case (em)
      mts_pkg::EM_A: emit_char(mts_pkg::CH_A);
      mts_pkg::EM_AM: begin
        emit_char(mts_pkg::CH_A);
        emit_char(mts_pkg::CH_M);
      end
      mts_pkg::EM_AMP: begin
        emit_char(mts_pkg::CH_A);
        emit_char(mts_pkg::CH_M);
        emit_char(mts_pkg::CH_P);
      end
      mts_pkg::EM_L: emit_char(mts_pkg::CH_L);
      mts_pkg::EM_LT: begin
        emit_char(mts_pkg::CH_L);
        emit_char(mts_pkg::CH_T);
      end
      mts_pkg::EM_G: emit_char(mts_pkg::CH_G);
      mts_pkg::EM_GT: begin
        emit_char(mts_pkg::CH_G);
        emit_char(mts_pkg::CH_T);
      end
      default: ;
    endcase
    sup = 1'b0;
    em = mts_pkg::EM_IDLE;
  endtask

  task automatic decode_char(input logic [7:0] c);
    emit_char(c);
    sup = 1'b0;
    em = mts_pkg::EM_IDLE;
  endtask

  task automatic entity_step(input logic [7:0] c);
    if (em == mts_pkg::EM_AMP1 && c == mts_pkg::CH_A) em = mts_pkg::EM_A;
    else if (em == mts_pkg::EM_AMP1 && c == mts_pkg::CH_L) em = mts_pkg::EM_L;
    else if (em == mts_pkg::EM_AMP1 && c == mts_pkg::CH_G) em = mts_pkg::EM_G;
    else if (em == mts_pkg::EM_AMP1 && c == mts_pkg::CH_HASH) begin
      em = mts_pkg::EM_IDLE;
      num_skip = 1'b1;
    end
    else if (em == mts_pkg::EM_A && c == mts_pkg::CH_M) em = mts_pkg::EM_AM;
    else if (em == mts_pkg::EM_AM && c == mts_pkg::CH_P) em = mts_pkg::EM_AMP;
    else if (em == mts_pkg::EM_L && c == mts_pkg::CH_T) em = mts_pkg::EM_LT;
    else if (em == mts_pkg::EM_G && c == mts_pkg::CH_T) em = mts_pkg::EM_GT;
    else if (c == mts_pkg::CH_SEMI && em == mts_pkg::EM_AMP) decode_char(mts_pkg::CH_AMP);
    else if (c == mts_pkg::CH_SEMI && em == mts_pkg::EM_LT) decode_char(mts_pkg::CH_LT);
    else if (c == mts_pkg::CH_SEMI && em == mts_pkg::EM_GT) decode_char(mts_pkg::CH_GT);
    else begin
      // mismatch: flush what matched, then treat the byte as plain
      replay_prefix();
      plain_step(c);
    end
  endtask

  task automatic strip_byte(input logic [7:0] c, input logic lst);
    burst.delete();
    if (num_skip) begin
      if (c == mts_pkg::CH_SEMI) begin
        emit_char(mts_pkg::CH_SPACE);
        sup = 1'b0;
        num_skip = 1'b0;
      end
    end else if (em != mts_pkg::EM_IDLE) begin
      entity_step(c);
    end else begin
      plain_step(c);
    end
    // end of text: flush pending entity, close numeric, then terminator
    if (lst) begin
      if (em != mts_pkg::EM_IDLE) replay_prefix();
      if (num_skip) begin
        emit_char(mts_pkg::CH_SPACE);
        num_skip = 1'b0;
      end
      burst.push_back(text_result_t'{b: mts_pkg::CH_NUL, rl: 1'b0, eot: 1'b1,
                                     len: emitted});
      tag_open = 1'b0;
      sup = 1'b0;
      em = mts_pkg::EM_IDLE;
      emitted = 32'd0;
    end
    if (burst.size() > 0) burst[burst.size() - 1].rl = 1'b1;
    foreach (burst[i]) plain_q.push_back(burst[i]);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_item(input logic [7:0] c, input logic lst);
    markup_q.push_back(markup_item_t'{b: c, lst: lst});
  endtask

  task automatic push_text(input string s, input logic term);
    for (int i = 0; i < s.len(); i++) begin
      push_item(s[i], term && (i == s.len() - 1));
    end
  endtask

  function automatic string entity_name();
    case ($urandom_range(0, 2))
      0: return "amp";
      1: return "lt";
      default: return "gt";
    endcase
  endfunction

  task automatic push_token();
    token_t kind;
    string nm;
    int unsigned n;
    kind = token_t'($urandom_range(0, 7));
    case (kind)
      TK_WORD: begin
        n = $urandom_range(1, 6);
        repeat (n) push_item(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
      end
      TK_SPACE: begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) push_item(mts_pkg::CH_SPACE, 1'b0);
          else push_item(8'($urandom_range(mts_pkg::CH_TAB, mts_pkg::CH_CR)), 1'b0);
        end
      end
      TK_TAG: begin
        push_item(mts_pkg::CH_LT, 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) push_item(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
        push_item(mts_pkg::CH_GT, 1'b0);
      end
      TK_ENTITY: push_text({"&", entity_name(), ";"}, 1'b0);
      TK_PARTIAL: begin
        nm = entity_name();
        n = $urandom_range(0, nm.len());
        push_item(mts_pkg::CH_AMP, 1'b0);
        for (int i = 0; i < n; i++) push_item(nm[i], 1'b0);
        if ($urandom_range(0, 1) == 0) push_item(8'($urandom_range(0, 255)), 1'b0);
      end
      TK_NUMERIC: begin
        push_text("&#", 1'b0);
        n = $urandom_range(0, 4);
        repeat (n) push_item(8'($urandom_range(8'h30, 8'h39)), 1'b0);
        if ($urandom_range(0, 3) != 0) push_item(mts_pkg::CH_SEMI, 1'b0);
      end
      TK_STRAY_GT: push_item(mts_pkg::CH_GT, 1'b0);
      default: push_item(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  // ---------------------------------------------------------------- input driver

  always @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!text_valid || text_ready) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        text_valid <= 1'b0;
      end else if (markup_q.size() > 0) begin
        {text_byte, last_byte} <= markup_q.pop_front();
        text_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        text_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver stalls

  always @(posedge clk) begin
    ready_cycles = ready_cycles + 1;
    if (ready_cycles % 50 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= ($urandom_range(0, 1) == 0);
      2: result_ready <= (ready_cycles % 4 == 0);
      default: result_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (!rst) begin
      // check the result transfer against the oldest expected byte
      if (result_valid && result_ready) begin
        if (plain_q.size() == 0) begin
          $error("unexpected result: out_byte %h end_of_text %b", out_byte, end_of_text);
          mismatches++;
        end else begin
          want = plain_q.pop_front();
          if (out_byte !== want.b) begin
            $error("out_byte: expected %h, got %h", want.b, out_byte);
            mismatches++;
          end
          if (run_last !== want.rl) begin
            $error("run_last: expected %b, got %b", want.rl, run_last);
            mismatches++;
          end
          if (end_of_text !== want.eot) begin
            $error("end_of_text: expected %b, got %b", want.eot, end_of_text);
            mismatches++;
          end
          if (text_length !== want.len) begin
            $error("text_length: expected %0d, got %0d", want.len, text_length);
            mismatches++;
          end
        end
      end
      // predict the results of an input transfer
      if (text_valid && text_ready) begin
        strip_byte(text_byte, last_byte);
        accepted++;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    tag_open = 1'b0;
    sup = 1'b0;
    em = mts_pkg::EM_IDLE;
    num_skip = 1'b0;
    emitted = 32'd0;
    accepted = 0;
    mismatches = 0;
    cycle_count = 0;
    ready_cycles = 0;
    ready_mode = 0;

    // nested tag, collapsed whitespace, decoded and numeric entities,
    // markup inside a numeric entity, partial entity flushed at end of text
    push_text("a<b<>\t &lt;&#>;&am", 1'b1);
    // stray '>', mismatch after "&g", high byte, open numeric at end of text
    push_text(">&gt;&gx", 1'b0);
    push_item(8'hFF, 1'b0);
    push_text("&#", 1'b1);

    // random texts of well-formed fragments mixed with noise
    while (markup_q.size() < RANDOM_ITEMS) begin
      repeat ($urandom_range(1, 12)) push_token();
      markup_q[markup_q.size() - 1].lst = 1'b1;
    end
    total_items = markup_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (accepted < total_items) @(posedge clk);
    while (plain_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/mts_pkg.sv
src/mts_decode.sv
src/mts_burst_buf.sv
src/markup_tag_stripper_unit.sv
sim/markup_tag_stripper_unit_tb.sv
